@@ rtl/cpoc_pkg.sv @@
// Package for the circle pair overlap classifier: sizes, payload types, relation codes, root step.
package cpoc_pkg;

    // Field sizes
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    localparam int FRAC_BITS   = 8;
    localparam int GAP_W       = 21;
    localparam int REL_W       = 3;

    // Derived datapath widths
    localparam int DIFF_W  = COORD_BITS;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DSQ_W   = SQ_W + 1;
    localparam int RAD_W   = SQ_W + 2;
    localparam int RSUM_W  = RADIUS_BITS + 1;
    localparam int RSQ_W   = 2 * RSUM_W;
    localparam int RR_SQ_W = 2 * RADIUS_BITS;
    localparam int CMP_W   = (DSQ_W > RSQ_W) ? DSQ_W : RSQ_W;
    localparam int NSTEP   = COORD_BITS + 1 + FRAC_BITS;
    localparam int ROOT_W  = NSTEP;
    localparam int REM_W   = ROOT_W + 3;
    localparam int BASE_W  = RSUM_W + FRAC_BITS;
    localparam int GW0     = (ROOT_W > BASE_W) ? ROOT_W : BASE_W;
    localparam int GW      = (GW0 > GAP_W) ? GW0 : GAP_W;

    localparam logic [GW-1:0] GAP_MAX = GW'((64'd1 << GAP_W) - 64'd1);

    // Relation codes
    typedef enum logic [REL_W-1:0] {
        REL_APART     = 3'd0,
        REL_LESS_HALF = 3'd1,
        REL_MORE_HALF = 3'd2,
        REL_INCLUSION = 3'd3,
        REL_TRUNK     = 3'd4
    } relation_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  ref_x;
        logic [COORD_BITS-1:0]  ref_y;
        logic [RADIUS_BITS-1:0] ref_rad;
        logic [COORD_BITS-1:0]  cmp_x;
        logic [COORD_BITS-1:0]  cmp_y;
        logic [RADIUS_BITS-1:0] cmp_rad;
    } pair_t;

    typedef struct packed {
        relation_t          relation;
        logic [GAP_W-1:0]   gap;
        logic               trunk_hit;
    } verdict_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } root_state_t;

    // One restoring square root step: bring down a bit pair, try to subtract 4*root+1
    function automatic root_state_t root_step(input logic [ROOT_W-1:0] root,
                                              input logic [REM_W-1:0]  rem,
                                              input logic [1:0]        bits);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        root_state_t      res;
        rem_sh = {rem[REM_W-3:0], bits};
        trial  = REM_W'({root, 2'b01});
        if (rem_sh >= trial)
        begin
            res.rem  = rem_sh - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = rem_sh;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

@@ rtl/circle_pair_overlap_classifier_unit.sv @@
// Top level of the circle pair overlap classifier: squares, class decision, pipelined root, gap.
//
// Takes one circle pair per cycle when pair_stall is low and returns one verdict per pair, in
// order. The pipeline depth is set by the centre-distance square root, which resolves one
// result bit per pipeline stage (COORD_BITS + 1 integer bits and FRAC_BITS fraction bits);
// three stages ahead of it form the differences, the squares and the class decision, and one
// stage after it forms the gap. Each stage holds its item while the next one is full and
// stalled, and empty stages fill, so a stall at the output holds back the input only once
// the whole pipeline is occupied.
module circle_pair_overlap_classifier_unit
    import cpoc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pair_t    pair,
    input  logic     pair_valid,
    output logic     pair_stall,
    output verdict_t verdict,
    output logic     verdict_valid,
    input  logic     verdict_stall
);

    // Stage 1: differences and radius sums
    logic                   s1_vld_reg;
    logic [DIFF_W-1:0]      s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic [RADIUS_BITS-1:0] s1_rr_reg, s1_cr_reg, s1_dr_reg, s1_dr_next;
    logic [RSUM_W-1:0]      s1_rsum_reg, s1_rsum_next;
    logic                   s1_en;

    // Stage 2: squares
    logic                   s2_vld_reg;
    logic [SQ_W-1:0]        s2_dx2_reg, s2_dy2_reg, s2_dx2_next, s2_dy2_next;
    logic [RSQ_W-1:0]       s2_rsq_reg, s2_rsq_next;
    logic [RR_SQ_W-1:0]     s2_crsq_reg, s2_drsq_reg, s2_rrsq_reg;
    logic [RR_SQ_W-1:0]     s2_crsq_next, s2_drsq_next, s2_rrsq_next;
    logic                   s2_rr_gt_reg, s2_rr_gt_next;
    logic [RSUM_W-1:0]      s2_rsum_reg;
    logic                   s2_en;

    // Stage 3: squared distance and class
    logic                   s3_vld_reg;
    logic [DSQ_W-1:0]       s3_d2_reg, s3_d2_next;
    relation_t              s3_rel_reg, s3_rel_next;
    logic [RSUM_W-1:0]      s3_rsum_reg;
    logic                   s3_en;

    // Root stages
    logic                   rt_vld_reg  [NSTEP];
    logic [RAD_W-1:0]       rt_rad_reg  [NSTEP];
    logic [ROOT_W-1:0]      rt_root_reg [NSTEP];
    logic [REM_W-1:0]       rt_rem_reg  [NSTEP];
    relation_t              rt_rel_reg  [NSTEP];
    logic [RSUM_W-1:0]      rt_rsum_reg [NSTEP];
    logic                   rt_en       [NSTEP];
    logic                   rt_vld_in   [NSTEP];
    logic [RAD_W-1:0]       rt_rad_in   [NSTEP];
    logic [ROOT_W-1:0]      rt_root_in  [NSTEP];
    logic [REM_W-1:0]       rt_rem_in   [NSTEP];
    relation_t              rt_rel_in   [NSTEP];
    logic [RSUM_W-1:0]      rt_rsum_in  [NSTEP];
    root_state_t            rt_step     [NSTEP];

    // Output stage
    logic                   out_vld_reg;
    verdict_t               out_reg, out_next;
    logic                   out_en;

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        out_en = !out_vld_reg || !verdict_stall;
        rt_en[NSTEP-1] = !rt_vld_reg[NSTEP-1] || out_en;
        for (int k = NSTEP - 2; k >= 0; k--)
        begin
            rt_en[k] = !rt_vld_reg[k] || rt_en[k+1];
        end
        s3_en = !s3_vld_reg || rt_en[0];
        s2_en = !s2_vld_reg || s3_en;
        s1_en = !s1_vld_reg || s2_en;
    end

    assign pair_stall = !s1_en;

    // Stage 1 logic
    always_comb
    begin
        s1_dx_next   = (pair.ref_x > pair.cmp_x) ? pair.ref_x - pair.cmp_x
                                                 : pair.cmp_x - pair.ref_x;
        s1_dy_next   = (pair.ref_y > pair.cmp_y) ? pair.ref_y - pair.cmp_y
                                                 : pair.cmp_y - pair.ref_y;
        s1_rsum_next = RSUM_W'(pair.ref_rad) + RSUM_W'(pair.cmp_rad);
        // only used when the compared radius is not the smaller
        s1_dr_next   = pair.cmp_rad - pair.ref_rad;
    end

    // Stage 2 logic: one small multiplier per square
    always_comb
    begin
        s2_dx2_next   = SQ_W'(s1_dx_reg) * SQ_W'(s1_dx_reg);
        s2_dy2_next   = SQ_W'(s1_dy_reg) * SQ_W'(s1_dy_reg);
        s2_rsq_next   = RSQ_W'(s1_rsum_reg) * RSQ_W'(s1_rsum_reg);
        s2_crsq_next  = RR_SQ_W'(s1_cr_reg) * RR_SQ_W'(s1_cr_reg);
        s2_drsq_next  = RR_SQ_W'(s1_dr_reg) * RR_SQ_W'(s1_dr_reg);
        s2_rrsq_next  = RR_SQ_W'(s1_rr_reg) * RR_SQ_W'(s1_rr_reg);
        s2_rr_gt_next = s1_rr_reg > s1_cr_reg;
    end

    // Stage 3 logic: squared distance, then exact class tests in priority order
    always_comb
    begin
        logic [CMP_W-1:0] d2_e;
        s3_d2_next = DSQ_W'(s2_dx2_reg) + DSQ_W'(s2_dy2_reg);
        d2_e       = CMP_W'(s3_d2_next);
        priority if (d2_e >= CMP_W'(s2_rsq_reg))
            s3_rel_next = REL_APART;
        else if (s2_rr_gt_reg)
            s3_rel_next = REL_LESS_HALF;
        else if (d2_e > CMP_W'(s2_crsq_reg))
            s3_rel_next = REL_LESS_HALF;
        else if (d2_e > CMP_W'(s2_drsq_reg))
            s3_rel_next = REL_MORE_HALF;
        else if (d2_e > CMP_W'(s2_rrsq_reg))
            s3_rel_next = REL_INCLUSION;
        else
            s3_rel_next = REL_TRUNK;
    end

    // Root stage inputs and one root step per stage
    always_comb
    begin
        rt_vld_in[0]  = s3_vld_reg;
        rt_rad_in[0]  = RAD_W'(s3_d2_reg);
        rt_root_in[0] = '0;
        rt_rem_in[0]  = '0;
        rt_rel_in[0]  = s3_rel_reg;
        rt_rsum_in[0] = s3_rsum_reg;
        for (int k = 1; k < NSTEP; k++)
        begin
            rt_vld_in[k]  = rt_vld_reg[k-1];
            rt_rad_in[k]  = rt_rad_reg[k-1];
            rt_root_in[k] = rt_root_reg[k-1];
            rt_rem_in[k]  = rt_rem_reg[k-1];
            rt_rel_in[k]  = rt_rel_reg[k-1];
            rt_rsum_in[k] = rt_rsum_reg[k-1];
        end
        for (int k = 0; k < NSTEP; k++)
        begin
            rt_step[k] = root_step(rt_root_in[k], rt_rem_in[k], rt_rad_in[k][RAD_W-1 -: 2]);
        end
    end

    // Output logic: gap from the root less the scaled radius sum, saturated
    always_comb
    begin
        logic [GW-1:0] root_e;
        logic [GW-1:0] base_e;
        logic [GW-1:0] diff;
        root_e = GW'(rt_root_reg[NSTEP-1]);
        base_e = GW'(rt_rsum_reg[NSTEP-1]) << FRAC_BITS;
        diff   = (root_e > base_e) ? root_e - base_e : '0;
        if (diff > GAP_MAX)
            diff = GAP_MAX;
        out_next.relation  = rt_rel_reg[NSTEP-1];
        out_next.gap       = (rt_rel_reg[NSTEP-1] == REL_APART) ? diff[GAP_W-1:0] : '0;
        out_next.trunk_hit = rt_rel_reg[NSTEP-1] == REL_TRUNK;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < NSTEP; k++)
            begin
                rt_vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (s1_en)
                s1_vld_reg <= pair_valid;
            if (s2_en)
                s2_vld_reg <= s1_vld_reg;
            if (s3_en)
                s3_vld_reg <= s2_vld_reg;
            for (int k = 0; k < NSTEP; k++)
            begin
                if (rt_en[k])
                    rt_vld_reg[k] <= rt_vld_in[k];
            end
            if (out_en)
                out_vld_reg <= rt_vld_reg[NSTEP-1];
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_rr_reg   <= pair.ref_rad;
            s1_cr_reg   <= pair.cmp_rad;
            s1_dr_reg   <= s1_dr_next;
            s1_rsum_reg <= s1_rsum_next;
        end
        if (s2_en)
        begin
            s2_dx2_reg   <= s2_dx2_next;
            s2_dy2_reg   <= s2_dy2_next;
            s2_rsq_reg   <= s2_rsq_next;
            s2_crsq_reg  <= s2_crsq_next;
            s2_drsq_reg  <= s2_drsq_next;
            s2_rrsq_reg  <= s2_rrsq_next;
            s2_rr_gt_reg <= s2_rr_gt_next;
            s2_rsum_reg  <= s1_rsum_reg;
        end
        if (s3_en)
        begin
            s3_d2_reg   <= s3_d2_next;
            s3_rel_reg  <= s3_rel_next;
            s3_rsum_reg <= s2_rsum_reg;
        end
        for (int k = 0; k < NSTEP; k++)
        begin
            if (rt_en[k])
            begin
                rt_rad_reg[k]  <= {rt_rad_in[k][RAD_W-3:0], 2'b00};
                rt_root_reg[k] <= rt_step[k].root;
                rt_rem_reg[k]  <= rt_step[k].rem;
                rt_rel_reg[k]  <= rt_rel_in[k];
                rt_rsum_reg[k] <= rt_rsum_in[k];
            end
        end
        if (out_en)
            out_reg <= out_next;
    end

    assign verdict       = out_reg;
    assign verdict_valid = out_vld_reg;

    // Trunk flag travels with its class
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (verdict.trunk_hit == (verdict.relation == REL_TRUNK)))
        else $error("trunk flag disagrees with relation");

    // Only separated pairs carry a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && verdict.gap != '0) |-> (verdict.relation == REL_APART))
        else $error("gap reported for an overlapping pair");

    // Input is held back only when the difference, square and class stages are all occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> (s1_vld_reg && s2_vld_reg && s3_vld_reg))
        else $error("input stalled with room in the pipeline");

    // A stalled result stays in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && verdict_stall) |=> (out_vld_reg && $stable(out_reg)))
        else $error("output register changed under stall");

endmodule
